FILE: sv/csma_ack_mac_controller_assert.svh
// Assertion macros shared by the MAC controller modules.
`ifndef CSMA_ACK_MAC_CONTROLLER_ASSERT_SVH
`define CSMA_ACK_MAC_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CSMACK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CSMACK_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/csmack_pkg.sv
// Types, codes and constants of the CSMA/CA MAC controller.
`timescale 1ns / 1ps
`default_nettype none
package csmack_pkg;

    localparam int CSMACK_ADDR_WIDTH  = 16;
    localparam int CSMACK_TIMER_WIDTH = 16;

    localparam int RAND_W      = 16;
    localparam int DIV_STEPS   = RAND_W;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam logic [15:0] MIN_CONTEND = 16'd5;

    // register indexes
    localparam logic [2:0] REG_NODE_ADDR   = 3'd0;
    localparam logic [2:0] REG_BASE_CW     = 3'd1;
    localparam logic [2:0] REG_MAX_CW      = 3'd2;
    localparam logic [2:0] REG_ACK_CW      = 3'd3;
    localparam logic [2:0] REG_ACK_WAIT    = 3'd4;
    localparam logic [2:0] REG_NAV_DUR     = 3'd5;
    localparam logic [2:0] REG_MAX_RETRIES = 3'd6;

    // register reset values
    localparam logic [15:0] RST_BASE_CW     = 16'd32;
    localparam logic [15:0] RST_MAX_CW      = 16'd1024;
    localparam logic [15:0] RST_ACK_CW      = 16'd8;
    localparam logic [15:0] RST_ACK_WAIT    = 16'd64;
    localparam logic [15:0] RST_NAV_DUR     = 16'd64;
    localparam logic [7:0]  RST_MAX_RETRIES = 8'd3;

    // event codes
    localparam logic [2:0] OP_TX_REQ   = 3'd0;
    localparam logic [2:0] OP_RX_FRAME = 3'd1;
    localparam logic [2:0] OP_TX_DONE  = 3'd2;
    localparam logic [2:0] OP_RX_START = 3'd3;
    localparam logic [2:0] OP_RX_FAIL  = 3'd4;
    localparam logic [2:0] OP_TICK     = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_CONTEND   = 3'd1,
        PH_SEND_DATA = 3'd2,
        PH_SEND_ACK  = 3'd3,
        PH_WAIT_ACK  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        PL_NONE = 2'd0,
        PL_DATA = 2'd1,
        PL_ACK  = 2'd2,
        PL_WAIT = 2'd3
    } plan_t;

    typedef enum logic [1:0] {
        RADIO_SLEEP  = 2'd0,
        RADIO_LISTEN = 2'd1,
        RADIO_TX     = 2'd2
    } radio_t;

    typedef enum logic [1:0] {
        SEND_NONE = 2'd0,
        SEND_DATA = 2'd1,
        SEND_ACK  = 2'd2
    } send_t;

    typedef enum logic [1:0] {
        TXS_NONE    = 2'd0,
        TXS_DONE    = 2'd1,
        TXS_FAILED  = 2'd2,
        TXS_DROPPED = 2'd3
    } txstat_t;

    typedef enum logic [1:0] {
        CS_IDLE   = 2'd0,
        CS_LOAD   = 2'd1,
        CS_DIV    = 2'd2,
        CS_COMMIT = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/csmack_ctrl.sv
// Sequencer: capture, serial remainder, commit and result handoff.
`timescale 1ns / 1ps
`default_nettype none
`include "csma_ack_mac_controller_assert.svh"
module csmack_ctrl
    import csmack_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output ctl_cmd_t        cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    ctl_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_tvalid) state_next = CS_LOAD;
            end
            CS_LOAD: begin
                state_next = CS_DIV;
                cnt_next   = '0;
            end
            CS_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = CS_COMMIT;
            end
            CS_COMMIT: begin
                if (!status.out_stall) state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            CS_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CS_LOAD:   cmd.div_load = 1'b1;
            CS_DIV:    cmd.div_step = 1'b1;
            CS_COMMIT: cmd.commit   = !status.out_stall;
            default: ;
        endcase
    end

    `CSMACK_ASSERT_NXT(a_accept_loads, aclk, aresetn, s_tvalid && s_tready,
        state_reg == CS_LOAD, "accepted beat did not start the remainder load")
    `CSMACK_ASSERT_IMP(a_commit_free, aclk, aresetn, cmd.commit, !status.out_stall,
        "commit while result register stalled")
    `CSMACK_ASSERT_NXT(a_div_to_commit, aclk, aresetn,
        state_reg == CS_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1),
        state_reg == CS_COMMIT, "remainder did not finish in its step count")

endmodule
`default_nettype wire

FILE: sv/csmack_dp.sv
// Datapath: config registers, protocol state, event update and serial remainder.
`timescale 1ns / 1ps
`default_nettype none
`include "csma_ack_mac_controller_assert.svh"
module csmack_dp
    import csmack_pkg::*;
#(
    parameter int ADDR_WIDTH  = CSMACK_ADDR_WIDTH,
    parameter int TIMER_WIDTH = CSMACK_TIMER_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ctl_cmd_t              cmd,
    output dp_status_t                 status,
    input  wire logic [2:0]            in_op,
    input  wire logic [ADDR_WIDTH-1:0] in_dest,
    input  wire logic [ADDR_WIDTH-1:0] in_src,
    input  wire logic                  in_is_ack,
    input  wire logic                  in_busy,
    input  wire logic                  in_rcv,
    input  wire logic [RAND_W-1:0]     in_rand,
    input  wire logic                  cfg_wr,
    input  wire logic [2:0]            cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [CFG_DATA_W-1:0]      cfg_rdata,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ADDR_WIDTH+9:0]      out_data
);

    localparam int AW = ADDR_WIDTH;
    localparam int TW = TIMER_WIDTH;
    localparam logic [AW-1:0] BCAST = '1;

    typedef struct packed {
        logic [2:0]    op;
        logic [AW-1:0] dest;
        logic [AW-1:0] src;
        logic          ack;
        logic          busy;
        logic          rcv;
        logic [15:0]   rnd;
    } in_t;

    typedef struct packed {
        logic [AW-1:0] node;
        logic [15:0]   base_cw;
        logic [15:0]   max_cw;
        logic [15:0]   ack_cw;
        logic [15:0]   ack_wait;
        logic [15:0]   nav_dur;
        logic [7:0]    max_ret;
    } cfg_t;

    typedef struct packed {
        phase_t        ph;
        plan_t         pl;
        logic          fp;
        logic [AW-1:0] pdest;
        logic [AW-1:0] ackt;
        logic          navb;
        logic [TW-1:0] navr;
        logic [TW-1:0] pc;
        logic          pa;
        logic [15:0]   cw;
        logic [7:0]    rl;
        radio_t        rs;
        send_t         osend;
        logic [AW-1:0] otgt;
        logic          odel;
        txstat_t       ostat;
        logic [15:0]   span;
    } ms_t;

    function automatic ms_t f_arm(ms_t s, logic [TW-1:0] t);
        s.pc = (t == '0) ? TW'(1) : t;
        s.pa = 1'b1;
        return s;
    endfunction

    function automatic ms_t f_disarm(ms_t s);
        s.pa = 1'b0;
        s.pc = '0;
        return s;
    endfunction

    function automatic ms_t f_grow(ms_t s, cfg_t c);
        logic [32:0] w;
        w = {16'd0, s.cw, 1'b0};
        if (w > 33'((64'd1 << TW) - 64'd1)) w = 33'((64'd1 << TW) - 64'd1);
        if (w > {17'd0, c.max_cw}) w = {17'd0, c.max_cw};
        s.cw = w[15:0];
        return s;
    endfunction

    function automatic ms_t f_start(ms_t s, logic [15:0] win, logic rcv, logic [15:0] rem);
        logic [TW+16:0] d;
        d = (TW+17)'(rem) + (TW+17)'(MIN_CONTEND);
        if (s.navb) begin
            s.pl = PL_NONE;
            s.ph = PH_IDLE;
            if (!rcv) s.rs = RADIO_SLEEP;
        end else begin
            s.span = (win >= MIN_CONTEND) ? win - (MIN_CONTEND - 16'd1) : 16'd1;
            s.ph   = PH_CONTEND;
            s.rs   = RADIO_LISTEN;
            s      = f_arm(s, d[TW-1:0]);
        end
        return s;
    endfunction

    function automatic ms_t f_eval(ms_t s, logic rcv, logic [15:0] rem);
        if (s.ph != PH_IDLE || rcv) return s;
        if (!s.navb) begin
            if (s.fp) begin
                s.pl = PL_DATA;
                return f_start(s, s.cw, rcv, rem);
            end
            s.rs = RADIO_LISTEN;
        end else begin
            s.rs = RADIO_SLEEP;
        end
        return s;
    endfunction

    function automatic ms_t f_expired(ms_t s, cfg_t c, in_t x, logic [15:0] rem);
        plan_t nxt;
        nxt = s.pl;
        if (s.ph == PH_CONTEND) begin
            s.rs = RADIO_LISTEN;
            if (x.busy || s.navb || x.rcv) begin
                s.ph = PH_IDLE;
                return f_eval(s, x.rcv, rem);
            end
            s.pl = PL_NONE;
            if (nxt == PL_ACK) begin
                s.ph    = PH_SEND_ACK;
                s.rs    = RADIO_TX;
                s.osend = SEND_ACK;
                s.otgt  = s.ackt;
            end else if (nxt == PL_DATA && s.fp) begin
                s.ph    = PH_SEND_DATA;
                s.pl    = (s.pdest == BCAST) ? PL_NONE : PL_WAIT;
                s.rs    = RADIO_TX;
                s.osend = SEND_DATA;
                s.otgt  = s.pdest;
            end else begin
                s.ph = PH_IDLE;
                s    = f_eval(s, x.rcv, rem);
            end
        end else if (s.ph == PH_WAIT_ACK) begin
            if (s.rl == 8'd0) begin
                s.ostat = TXS_FAILED;
                s.fp    = 1'b0;
            end else begin
                s.rl = s.rl - 8'd1;
                s    = f_grow(s, c);
            end
            s.ph = PH_IDLE;
            s    = f_eval(s, x.rcv, rem);
        end
        return s;
    endfunction

    function automatic ms_t f_rx(ms_t s, cfg_t c, in_t x, logic [15:0] rem);
        logic [TW-1:0] t;
        t = TW'(c.nav_dur);
        if (t == '0) t = TW'(1);
        if (s.ph == PH_WAIT_ACK && (!x.ack || x.dest != c.node)) begin
            s    = f_grow(s, c);
            s    = f_disarm(s);
            s.ph = PH_IDLE;
        end
        if (x.ack) begin
            if (x.dest == c.node && s.ph == PH_WAIT_ACK && s.fp && x.src == s.pdest) begin
                s       = f_disarm(s);
                s.cw    = c.base_cw;
                s.ostat = TXS_DONE;
                s.fp    = 1'b0;
                s.ph    = PH_IDLE;
            end
        end else if (x.dest == c.node) begin
            s.ackt = x.src;
            s.odel = 1'b1;
            s.pl   = PL_ACK;
            s      = f_start(s, c.ack_cw, x.rcv, rem);
        end else if (x.dest == BCAST) begin
            s      = f_disarm(s);
            s.ph   = PH_IDLE;
            s.pl   = PL_NONE;
            s.odel = 1'b1;
        end else begin
            s    = f_disarm(s);
            s.ph = PH_IDLE;
            s.pl = PL_NONE;
            // NAV only ever grows while busy
            if (!s.navb || t > s.navr) begin
                s.navb = 1'b1;
                s.navr = t;
            end
        end
        return f_eval(s, x.rcv, rem);
    endfunction

    function automatic ms_t f_txdone(ms_t s, cfg_t c, in_t x, logic [15:0] rem);
        if (s.ph == PH_SEND_ACK) begin
            s.ph = PH_IDLE;
            s    = f_eval(s, x.rcv, rem);
        end else if (s.ph == PH_SEND_DATA) begin
            if (s.pl == PL_WAIT) begin
                s.ph = PH_WAIT_ACK;
                s    = f_arm(s, TW'(c.ack_wait));
            end else begin
                s.ph = PH_IDLE;
            end
            s.pl = PL_NONE;
            if (s.fp && s.pdest == BCAST) begin
                s.ostat = TXS_DONE;
                s.fp    = 1'b0;
            end
            s.rs = RADIO_LISTEN;
        end
        return s;
    endfunction

    function automatic ms_t f_tick(ms_t s, cfg_t c, in_t x, logic [15:0] rem);
        if (s.pa) begin
            s.pc = s.pc - TW'(1);
            if (s.pc == '0) begin
                s.pa = 1'b0;
                s    = f_expired(s, c, x, rem);
            end
        end
        if (s.navb) begin
            s.navr = s.navr - TW'(1);
            if (s.navr == '0) begin
                s.navb = 1'b0;
                s      = f_eval(s, x.rcv, rem);
            end
        end
        return s;
    endfunction

    function automatic ms_t f_step(ms_t s0, cfg_t c, in_t x, logic [15:0] rem);
        ms_t s;
        s       = s0;
        s.osend = SEND_NONE;
        s.otgt  = '0;
        s.odel  = 1'b0;
        s.ostat = TXS_NONE;
        s.span  = 16'd1;
        unique case (x.op)
            OP_TX_REQ: begin
                if (s.fp) begin
                    s.ostat = TXS_DROPPED;
                end else begin
                    s.fp    = 1'b1;
                    s.pdest = x.dest;
                    s       = f_eval(s, x.rcv, rem);
                    s.rl    = c.max_ret;
                end
            end
            OP_RX_FRAME: s = f_rx(s, c, x, rem);
            OP_TX_DONE:  s = f_txdone(s, c, x, rem);
            OP_RX_START: begin
                if (s.ph == PH_CONTEND) begin
                    s    = f_disarm(s);
                    s.ph = PH_IDLE;
                    s.pl = PL_NONE;
                end
            end
            OP_RX_FAIL:  s = f_eval(s, x.rcv, rem);
            OP_TICK:     s = f_tick(s, c, x, rem);
            default: ;
        endcase
        return s;
    endfunction

    cfg_t  cfg_reg;
    in_t   in_reg;
    ms_t   st_reg, st_next, st_probe;
    logic  out_valid_reg;
    logic [AW+9:0] out_reg;
    logic [15:0]   dv_span_reg, dv_q_reg;
    logic [16:0]   dv_r_reg, dv_r_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node     <= '0;
            cfg_reg.base_cw  <= RST_BASE_CW;
            cfg_reg.max_cw   <= RST_MAX_CW;
            cfg_reg.ack_cw   <= RST_ACK_CW;
            cfg_reg.ack_wait <= RST_ACK_WAIT;
            cfg_reg.nav_dur  <= RST_NAV_DUR;
            cfg_reg.max_ret  <= RST_MAX_RETRIES;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_NODE_ADDR:   cfg_reg.node     <= AW'(cfg_wdata[15:0]);
                REG_BASE_CW:     cfg_reg.base_cw  <= cfg_wdata[15:0];
                REG_MAX_CW:      cfg_reg.max_cw   <= cfg_wdata[15:0];
                REG_ACK_CW:      cfg_reg.ack_cw   <= cfg_wdata[15:0];
                REG_ACK_WAIT:    cfg_reg.ack_wait <= cfg_wdata[15:0];
                REG_NAV_DUR:     cfg_reg.nav_dur  <= cfg_wdata[15:0];
                REG_MAX_RETRIES: cfg_reg.max_ret  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_NODE_ADDR:   cfg_rdata = CFG_DATA_W'(cfg_reg.node);
            REG_BASE_CW:     cfg_rdata = CFG_DATA_W'(cfg_reg.base_cw);
            REG_MAX_CW:      cfg_rdata = CFG_DATA_W'(cfg_reg.max_cw);
            REG_ACK_CW:      cfg_rdata = CFG_DATA_W'(cfg_reg.ack_cw);
            REG_ACK_WAIT:    cfg_rdata = CFG_DATA_W'(cfg_reg.ack_wait);
            REG_NAV_DUR:     cfg_rdata = CFG_DATA_W'(cfg_reg.nav_dur);
            REG_MAX_RETRIES: cfg_rdata = CFG_DATA_W'(cfg_reg.max_ret);
            default:         cfg_rdata = '0;
        endcase
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg.op   <= in_op;
            in_reg.dest <= in_dest;
            in_reg.src  <= in_src;
            in_reg.ack  <= in_is_ack;
            in_reg.busy <= in_busy;
            in_reg.rcv  <= in_rcv;
            in_reg.rnd  <= in_rand;
        end
    end

    // span does not depend on the remainder, so a probe pass finds it
    always_comb st_probe = f_step(st_reg, cfg_reg, in_reg, 16'd0);
    always_comb st_next  = f_step(st_reg, cfg_reg, in_reg, dv_r_reg[15:0]);

    // restoring remainder, one dividend bit per step
    always_comb begin
        dv_r_next = {dv_r_reg[15:0], dv_q_reg[15]};
        if (dv_r_next >= {1'b0, dv_span_reg}) dv_r_next = dv_r_next - {1'b0, dv_span_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dv_span_reg <= st_probe.span;
            dv_q_reg    <= in_reg.rnd;
            dv_r_reg    <= '0;
        end else if (cmd.div_step) begin
            dv_q_reg <= {dv_q_reg[14:0], 1'b0};
            dv_r_reg <= dv_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.ph    <= PH_IDLE;
            st_reg.pl    <= PL_NONE;
            st_reg.fp    <= 1'b0;
            st_reg.pdest <= '0;
            st_reg.ackt  <= '0;
            st_reg.navb  <= 1'b0;
            st_reg.navr  <= '0;
            st_reg.pc    <= '0;
            st_reg.pa    <= 1'b0;
            st_reg.cw    <= RST_BASE_CW;
            st_reg.rl    <= '0;
            st_reg.rs    <= RADIO_LISTEN;
            st_reg.osend <= SEND_NONE;
            st_reg.otgt  <= '0;
            st_reg.odel  <= 1'b0;
            st_reg.ostat <= TXS_NONE;
            st_reg.span  <= 16'd1;
        end else if (cmd.commit) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= {st_next.ph, st_next.ostat, st_next.odel, st_next.otgt,
                        st_next.osend, st_next.rs};
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;
    assign status.out_stall = out_valid_reg && !out_ready;

    `CSMACK_ASSERT_NXT(a_commit_valid, aclk, aresetn, cmd.commit, out_valid_reg,
        "committed result not presented")
    `CSMACK_ASSERT_IMP(a_rem_range, aclk, aresetn, cmd.commit,
        dv_r_reg < {1'b0, dv_span_reg}, "remainder not below contention span")
    `CSMACK_ASSERT_IMP(a_armed_nonzero, aclk, aresetn, st_reg.pa, st_reg.pc != '0,
        "armed protocol timer holds zero")

endmodule
`default_nettype wire

FILE: sv/csma_ack_mac_controller.sv
// An accepted input beat is captured, loaded into the 16-step serial remainder unit
// that maps the random draw into the contention window, and then committed to the
// output register once that register is free; only one event is in process at a time.
// A finished result waits in its output register while the next event is taken.
// Reset: synchronous, active low; the config registers, sequencer and protocol state
// take their reset values.
`timescale 1ns / 1ps
`default_nettype none
module csma_ack_mac_controller
    import csmack_pkg::*;
#(
    parameter int ADDR_WIDTH  = CSMACK_ADDR_WIDTH,
    parameter int TIMER_WIDTH = CSMACK_TIMER_WIDTH,
    localparam int IN_BITS    = 3 + 2 * ADDR_WIDTH + 3 + RAND_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ADDR_WIDTH + 10,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // operation, dest_address, src_address, frame_is_ack, channel_busy,
    // receiving, random_draw
    input  wire logic [IN_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // radio_mode, send_frame, frame_target, deliver_rx, tx_status, protocol_phase
    output logic [OUT_W-1:0]           m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int AW = ADDR_WIDTH;

    ctl_cmd_t        cmd;
    dp_status_t      status;
    logic [AW+9:0]   out_data;

    csmack_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    csmack_dp #(
        .ADDR_WIDTH  (ADDR_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tdata[2:0]),
        .in_dest   (s_tdata[3 +: AW]),
        .in_src    (s_tdata[3 + AW +: AW]),
        .in_is_ack (s_tdata[3 + 2 * AW]),
        .in_busy   (s_tdata[4 + 2 * AW]),
        .in_rcv    (s_tdata[5 + 2 * AW]),
        .in_rand   (s_tdata[6 + 2 * AW +: RAND_W]),
        .cfg_wr    (psel && penable && pwrite),
        .cfg_idx   (paddr[4:2]),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = OUT_W'(out_data);
    assign pready  = 1'b1;

endmodule
`default_nettype wire

FILE: sim/csma_ack_mac_controller_tb.sv
// Self-checking testbench of the CSMA/CA MAC controller with acks, retries and NAV.
`timescale 1ns / 1ps
module csma_ack_mac_controller_tb;
    import csmack_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [15:0] BCAST = 16'hFFFF;

    typedef struct packed {
        phase_t         ph;
        txstat_t        st;
        logic           dlv;
        logic [15:0]    tgt;
        send_t          snd;
        radio_t         rm;
    } mac_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    csma_ack_mac_controller u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // predictor state and registers
    logic [15:0] cfg_node, cfg_base_cw, cfg_max_cw, cfg_ack_cw, cfg_ack_wait, cfg_nav;
    logic [7:0]  cfg_retries;
    phase_t      ph;
    plan_t       plan;
    logic        fpend, navb, parm;
    logic [15:0] pdest, ackt, navr, pcnt, cw;
    logic [7:0]  retl;
    radio_t      radio;
    logic        c_rx, c_busy;
    logic [15:0] c_rand;
    send_t       o_send;
    logic [15:0] o_tgt;
    logic        o_dlv;
    txstat_t     o_st;

    logic [55:0] event_queue[$];
    mac_result_t expected_results[$];
    int errors = 0, items_in = 0, results_out = 0, cycles = 0, cfg_writes = 0;
    logic in_fire = 1'b0, out_fire = 1'b0, burst = 1'b0;
    int send_gap = 0, recv_stall = 0, long_hold = 0;
    logic long_done = 1'b0;

    function automatic void mac_reset();
        cfg_node = 0; cfg_base_cw = RST_BASE_CW; cfg_max_cw = RST_MAX_CW;
        cfg_ack_cw = RST_ACK_CW; cfg_ack_wait = RST_ACK_WAIT; cfg_nav = RST_NAV_DUR;
        cfg_retries = RST_MAX_RETRIES;
        ph = PH_IDLE; plan = PL_NONE; fpend = 0; pdest = 0; ackt = 0; navb = 0;
        navr = 0; pcnt = 0; parm = 0; cw = RST_BASE_CW; retl = 0; radio = RADIO_LISTEN;
    endfunction

    function automatic void arm_timer(int t);
        t = t & 16'hFFFF;
        pcnt = (t == 0) ? 16'd1 : 16'(t);
        parm = 1;
    endfunction

    function automatic void disarm_timer();
        parm = 0;
        pcnt = 0;
    endfunction

    function automatic void double_window();
        int w;
        w = int'(cw) * 2;
        if (w > 65535) w = 65535;
        if (w > int'(cfg_max_cw)) w = cfg_max_cw;
        cw = 16'(w);
    endfunction

    function automatic void begin_contention(logic [15:0] window);
        int span;
        if (navb) begin
            plan = PL_NONE;
            ph = PH_IDLE;
            if (!c_rx) radio = RADIO_SLEEP;
        end else begin
            span = (window >= MIN_CONTEND) ? int'(window) - 4 : 1;
            ph = PH_CONTEND;
            radio = RADIO_LISTEN;
            arm_timer(5 + int'(c_rand) % span);
        end
    endfunction

    function automatic void reevaluate();
        if (ph != PH_IDLE || c_rx) return;
        if (!navb) begin
            if (fpend) begin
                plan = PL_DATA;
                begin_contention(cw);
                return;
            end
            radio = RADIO_LISTEN;
        end else begin
            radio = RADIO_SLEEP;
        end
    endfunction

    function automatic void back_to_idle();
        ph = PH_IDLE;
        reevaluate();
    endfunction

    function automatic void timer_expired();
        plan_t nxt;
        if (ph == PH_CONTEND) begin
            nxt = plan;
            radio = RADIO_LISTEN;
            if (c_busy || navb || c_rx) begin
                back_to_idle();
                return;
            end
            plan = PL_NONE;
            if (nxt == PL_ACK) begin
                ph = PH_SEND_ACK; radio = RADIO_TX; o_send = SEND_ACK; o_tgt = ackt;
            end else if (nxt == PL_DATA && fpend) begin
                ph = PH_SEND_DATA;
                plan = (pdest == BCAST) ? PL_NONE : PL_WAIT;
                radio = RADIO_TX; o_send = SEND_DATA; o_tgt = pdest;
            end else begin
                back_to_idle();
            end
        end else if (ph == PH_WAIT_ACK) begin
            if (retl == 0) begin
                o_st = TXS_FAILED;
                fpend = 0;
            end else begin
                retl = retl - 1;
                double_window();
            end
            back_to_idle();
        end
    endfunction

    function automatic void frame_received(logic [15:0] dest, logic [15:0] src, logic is_ack);
        if (ph == PH_WAIT_ACK && (!is_ack || dest != cfg_node)) begin
            double_window();
            disarm_timer();
            ph = PH_IDLE;
        end
        if (is_ack) begin
            if (dest == cfg_node && ph == PH_WAIT_ACK && fpend && src == pdest) begin
                disarm_timer();
                cw = cfg_base_cw;
                o_st = TXS_DONE;
                fpend = 0;
                ph = PH_IDLE;
            end
        end else if (dest == cfg_node) begin
            ackt = src; o_dlv = 1; plan = PL_ACK;
            begin_contention(cfg_ack_cw);
        end else if (dest == BCAST) begin
            disarm_timer(); ph = PH_IDLE; plan = PL_NONE; o_dlv = 1;
        end else begin
            int t;
            disarm_timer(); ph = PH_IDLE; plan = PL_NONE;
            t = (cfg_nav == 0) ? 1 : cfg_nav;
            if (!navb || t > navr) begin
                navb = 1;
                navr = 16'(t);
            end
        end
        reevaluate();
    endfunction

    function automatic mac_result_t predict_event(logic [55:0] d);
        mac_result_t r;
        c_busy = d[36]; c_rx = d[37]; c_rand = d[53:38];
        o_send = SEND_NONE; o_tgt = 0; o_dlv = 0; o_st = TXS_NONE;
        case (d[2:0])
            OP_TX_REQ: begin
                if (fpend) o_st = TXS_DROPPED;
                else begin
                    fpend = 1; pdest = d[18:3];
                    reevaluate();
                    retl = cfg_retries;
                end
            end
            OP_RX_FRAME: frame_received(d[18:3], d[34:19], d[35]);
            OP_TX_DONE: begin
                if (ph == PH_SEND_ACK) back_to_idle();
                else if (ph == PH_SEND_DATA) begin
                    if (plan == PL_WAIT) begin
                        ph = PH_WAIT_ACK;
                        arm_timer(cfg_ack_wait);
                    end else ph = PH_IDLE;
                    plan = PL_NONE;
                    if (fpend && pdest == BCAST) begin
                        o_st = TXS_DONE;
                        fpend = 0;
                    end
                    radio = RADIO_LISTEN;
                end
            end
            OP_RX_START: begin
                if (ph == PH_CONTEND) begin
                    disarm_timer(); ph = PH_IDLE; plan = PL_NONE;
                end
            end
            OP_RX_FAIL: reevaluate();
            OP_TICK: begin
                // protocol timer first, then NAV
                if (parm) begin
                    pcnt = pcnt - 1;
                    if (pcnt == 0) begin
                        parm = 0;
                        timer_expired();
                    end
                end
                if (navb) begin
                    navr = navr - 1;
                    if (navr == 0) begin
                        navb = 0;
                        reevaluate();
                    end
                end
            end
            default: ;
        endcase
        r.ph = ph; r.st = o_st; r.dlv = o_dlv; r.tgt = o_tgt; r.snd = o_send; r.rm = radio;
        return r;
    endfunction

    function automatic logic [55:0] pack_event(logic [2:0] op, logic [15:0] dest,
                                               logic [15:0] src, logic ack, logic busy,
                                               logic rx, logic [15:0] rnd);
        return {2'b00, rnd, rx, busy, ack, src, dest, op};
    endfunction

    // monitor and predictor
    always @(posedge aclk) begin
        mac_result_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("csma_ack_mac_controller_tb NOT OK");
            $finish;
        end
        out_fire <= m_tvalid && m_tready;
        in_fire <= s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            got = mac_result_t'(m_tdata[25:0]);
            results_out <= results_out + 1;
            if (expected_results.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got.ph !== want.ph || got.st !== want.st || got.dlv !== want.dlv ||
                    got.tgt !== want.tgt || got.snd !== want.snd || got.rm !== want.rm) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("mismatch #%0d: exp ph=%0d st=%0d dlv=%0d tgt=%h snd=%0d rm=%0d, got ph=%0d st=%0d dlv=%0d tgt=%h snd=%0d rm=%0d",
                                 results_out, want.ph, want.st, want.dlv, want.tgt, want.snd,
                                 want.rm, got.ph, got.st, got.dlv, got.tgt, got.snd, got.rm);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(predict_event(s_tdata));
            items_in <= items_in + 1;
        end
    end

    // event driver
    always @(negedge aclk) begin
        logic nv;
        logic [55:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (!aresetn) nv = 1'b0;
        else if (!s_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                nv = 1'b0;
            end else if (event_queue.size() > 0) begin
                nd = event_queue.pop_front();
                nv = 1'b1;
                send_gap = burst ? 0 : $urandom_range(0, 10);
            end else nv = 1'b0;
        end
        s_tvalid <= nv;
        s_tdata <= nd;
    end

    // result receiver, with one long hold-off to back up the block
    always @(negedge aclk) begin
        logic rdy;
        if (out_fire) recv_stall = burst ? 0 : $urandom_range(0, 10);
        if (!long_done && results_out >= 300) begin
            long_done = 1'b1;
            long_hold = 500;
        end
        if (long_hold > 0) begin
            long_hold = long_hold - 1;
            rdy = 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            rdy = 1'b0;
        end else rdy = aresetn;
        m_tready <= rdy;
    end

    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = {16'h0, val};
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            REG_NODE_ADDR:   cfg_node = val;
            REG_BASE_CW:     cfg_base_cw = val;
            REG_MAX_CW:      cfg_max_cw = val;
            REG_ACK_CW:      cfg_ack_cw = val;
            REG_ACK_WAIT:    cfg_ack_wait = val;
            REG_NAV_DUR:     cfg_nav = val;
            REG_MAX_RETRIES: cfg_retries = val[7:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_drained();
        wait (event_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_addr(logic [15:0] node);
        case ($urandom_range(0, 5))
            0: return node;
            1: return BCAST;
            2: return 16'h0001;
            3: return 16'h0002;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic fill_random(int n);
        int k;
        logic [2:0] op;
        logic [15:0] a, b;
        for (k = 0; k < n; k++) begin
            a = pick_addr(cfg_node);
            b = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 2)) : 16'($urandom);
            case ($urandom_range(0, 99)) inside
                [0:49]:  op = OP_TICK;
                [50:57]: op = OP_TX_REQ;
                [58:69]: op = OP_TX_DONE;
                [70:83]: begin
                    op = OP_RX_FRAME;
                    // acks mostly well formed: to us, from the likely destination
                    if ($urandom_range(0, 1)) a = cfg_node;
                end
                [84:89]: op = OP_RX_START;
                [90:95]: op = OP_RX_FAIL;
                default: op = 3'($urandom_range(0, 7));
            endcase
            event_queue.push_back(pack_event(op, a, b, 1'($urandom),
                                  $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0,
                                  16'($urandom)));
        end
    endtask

    initial begin
        mac_reset();
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // directed: every event kind, broadcast, NAV, own-address request, unknown codes
        event_queue.push_back(pack_event(OP_RX_FAIL, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_TX_REQ, 16'h0000, 0, 0, 0, 0, 16'hFFFF));
        event_queue.push_back(pack_event(OP_TX_REQ, 16'h0002, 0, 0, 0, 0, 0));
        repeat (6) event_queue.push_back(pack_event(OP_TICK, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_RX_START, 0, 0, 0, 0, 1, 0));
        event_queue.push_back(pack_event(OP_RX_FAIL, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_TX_DONE, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_RX_FRAME, 16'h0000, 16'hFFFF, 0, 0, 0, 16'hFFFF));
        event_queue.push_back(pack_event(OP_RX_FRAME, BCAST, 16'h1234, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_RX_FRAME, 16'h00A5, 16'h0001, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_TICK, 0, 0, 0, 1, 1, 0));
        event_queue.push_back(pack_event(OP_RX_FRAME, 16'h0000, 16'h0000, 1, 1, 0, 0));
        event_queue.push_back(pack_event(3'd6, BCAST, BCAST, 1, 1, 1, 16'hFFFF));
        event_queue.push_back(pack_event(3'd7, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_TX_DONE, 0, 0, 0, 0, 0, 0));
        event_queue.push_back(pack_event(OP_TICK, 0, 0, 0, 0, 0, 0));
        wait_drained();

        burst = 1'b0;
        fill_random(390);
        wait_drained();

        reg_write(REG_NODE_ADDR, 16'h0003);
        reg_write(REG_BASE_CW, 16'd5);
        reg_write(REG_MAX_CW, 16'd5);
        reg_write(REG_ACK_CW, 16'd5);
        reg_write(REG_ACK_WAIT, 16'd1);
        reg_write(REG_NAV_DUR, 16'd1);
        reg_write(REG_MAX_RETRIES, 8'd0);
        burst = 1'b1;
        fill_random(380);
        wait_drained();

        reg_write(REG_NODE_ADDR, 16'hFFFE);
        reg_write(REG_BASE_CW, 16'hFFFF);
        reg_write(REG_MAX_CW, 16'hFFFF);
        reg_write(REG_ACK_CW, 16'hFFFF);
        reg_write(REG_ACK_WAIT, 16'hFFFF);
        reg_write(REG_NAV_DUR, 16'hFFFF);
        reg_write(REG_MAX_RETRIES, 8'd255);
        burst = 1'b0;
        fill_random(380);
        wait_drained();

        reg_write(REG_NODE_ADDR, 16'h0000);
        reg_write(REG_BASE_CW, 16'd8);
        reg_write(REG_MAX_CW, 16'd64);
        reg_write(REG_ACK_CW, 16'd6);
        reg_write(REG_ACK_WAIT, 16'd12);
        reg_write(REG_NAV_DUR, 16'd20);
        reg_write(REG_MAX_RETRIES, 8'd2);
        fill_random(380);
        wait_drained();

        reg_write(REG_NODE_ADDR, 16'($urandom_range(0, 65534)));
        reg_write(REG_BASE_CW, 16'($urandom_range(5, 40)));
        reg_write(REG_MAX_CW, 16'($urandom_range(5, 300)));
        reg_write(REG_ACK_CW, 16'($urandom_range(5, 20)));
        reg_write(REG_ACK_WAIT, 16'($urandom_range(1, 30)));
        reg_write(REG_NAV_DUR, 16'($urandom_range(1, 40)));
        reg_write(REG_MAX_RETRIES, 16'($urandom_range(0, 5)));
        fill_random(400);
        wait_drained();

        $display("covered %0d events and %0d result beats over %0d register writes",
                 items_in, results_out, cfg_writes);
        $display("settings ranged from minimum to maximum windows, timers and retries");
        if (errors == 0 && expected_results.size() == 0) begin
            $display("csma_ack_mac_controller_tb OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors,
                     expected_results.size());
            $display("csma_ack_mac_controller_tb NOT OK");
        end
        $finish;
    end

endmodule
